FILE: rtl/c420_pkg.sv
// c420_pkg: shared types and constants for the 4:2:0 chroma box downsampler
// no dependencies; used by the interfaces, the top level and c420_front

package c420_pkg;

	localparam int PIX_W       = 8;
	localparam int SUM_W       = PIX_W + 1;
	localparam int CFG_W       = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int POS_OUT_W   = 11;
	localparam int ROW_W       = 12;
	localparam int HEIGHT_MAX  = 4096;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

	// per-pixel context handed from the front end to the combine stage
	typedef struct packed {
		logic [PIX_W-1:0]     luma;
		logic [SUM_W-1:0]     hsum_cb;
		logic [SUM_W-1:0]     hsum_cr;
		logic                 hdone;
		logic                 pair;
		logic                 odd_row;
		logic                 last_row;
		logic                 frame_end;
		logic [POS_OUT_W-1:0] ccol;
		logic [POS_OUT_W-1:0] crow;
	} c420_ctx_t;

endpackage

FILE: rtl/c420_if.sv
// c420 channel interfaces: pixel input, pixel/chroma output, register write
// depends on c420_pkg

interface c420_pix_in_if;
	logic                     valid;
	logic                     ready;
	logic [c420_pkg::PIX_W-1:0] luma_in;
	logic [c420_pkg::PIX_W-1:0] red_diff_in;
	logic [c420_pkg::PIX_W-1:0] blue_diff_in;
	modport source (output valid, luma_in, red_diff_in, blue_diff_in, input ready);
	modport sink (input valid, luma_in, red_diff_in, blue_diff_in, output ready);
endinterface

interface c420_pix_out_if;
	logic                         valid;
	logic                         ready;
	logic [c420_pkg::PIX_W-1:0]     luma_out;
	logic                         chroma_valid;
	logic [c420_pkg::PIX_W-1:0]     blue_avg;
	logic [c420_pkg::PIX_W-1:0]     red_avg;
	logic [c420_pkg::POS_OUT_W-1:0] chroma_col;
	logic [c420_pkg::POS_OUT_W-1:0] chroma_row;
	logic                         frame_end;
	modport source (output valid, luma_out, chroma_valid, blue_avg, red_avg, chroma_col,
		chroma_row, frame_end, input ready);
	modport sink (input valid, luma_out, chroma_valid, blue_avg, red_avg, chroma_col,
		chroma_row, frame_end, output ready);
endinterface

interface c420_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [c420_pkg::CFG_IDX_W-1:0] index;
	logic [c420_pkg::CFG_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/chroma_420_box_downsampler.sv
// chroma_420_box_downsampler: top level, combine stage and output register
// depends on c420_pkg, c420_if, c420_front and c420_line_mem
//
// Takes one YCrCb pixel per clock in raster order and returns one result per
// pixel: luma passed through, plus the Cb/Cr average of a 2x2 block on the
// pixel that completes it (smaller blocks on an odd last column or row).
// Sustained rate is one pixel per cycle; input ready drops only while the
// stage-1 register is full and the output register is held by backpressure.
// A result moves from the stage-1 register into the output register and leaves
// from there when taken downstream. The line store (MAX_WIDTH/2 rounded up entries
// of 18 bits) is read when a pixel is taken and written when that pixel moves
// to the output register, with a bypass when the next pixel reads the same
// entry in that cycle. It has no clearing pass: an odd row only reads entries
// its even row wrote. Any write to the width or height register restarts the
// frame at the top-left pixel; write them only while no pixel is in flight.

module chroma_420_box_downsampler #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	c420_pix_in_if.sink     pix_in,
	c420_pix_out_if.source  pix_out,
	c420_cfg_if.sink        cfg
);

	localparam int CW     = $clog2(MAX_WIDTH + 1);
	localparam int DEPTH  = (MAX_WIDTH + 1) / 2;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DATA_W = 2 * c420_pkg::SUM_W;

	c420_pkg::c420_ctx_t ctx;
	logic [ADDR_W-1:0]   idx;
	logic                accept;

	c420_pkg::c420_ctx_t ctx_s1;
	logic [ADDR_W-1:0]   idx_s1;
	logic                valid_s1;
	logic                fwd_s1;
	logic [DATA_W-1:0]   fwd_data_s1;
	logic                fire_s1;

	logic [DATA_W-1:0]   rdata;
	logic [DATA_W-1:0]   stored;
	logic                we;
	logic [DATA_W-1:0]   wdata;

	logic [c420_pkg::SUM_W:0]   sum_cb;
	logic [c420_pkg::SUM_W:0]   sum_cr;
	logic [c420_pkg::PIX_W-1:0] avg_cb;
	logic [c420_pkg::PIX_W-1:0] avg_cr;
	logic                       cvalid;

	logic                         out_valid_q;
	logic [c420_pkg::PIX_W-1:0]     luma_q;
	logic                         cvalid_q;
	logic [c420_pkg::PIX_W-1:0]     blue_q;
	logic [c420_pkg::PIX_W-1:0]     red_q;
	logic [c420_pkg::POS_OUT_W-1:0] ccol_q;
	logic [c420_pkg::POS_OUT_W-1:0] crow_q;
	logic                         fend_q;

	assign fire_s1      = valid_s1 && (!out_valid_q || pix_out.ready);
	assign pix_in.ready = !valid_s1 || fire_s1;
	assign accept       = pix_in.valid && pix_in.ready;

	c420_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.CW        (CW),
		.ADDR_W    (ADDR_W)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (accept),
		.luma   (pix_in.luma_in),
		.cr     (pix_in.red_diff_in),
		.cb     (pix_in.blue_diff_in),
		.ctx    (ctx),
		.idx    (idx)
	);

	assign we    = fire_s1 && ctx_s1.hdone && !ctx_s1.odd_row && !ctx_s1.last_row;
	assign wdata = {ctx_s1.hsum_cb, ctx_s1.hsum_cr};

	c420_line_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (DATA_W)
	) u_line_mem (
		.clk   (clk),
		.we    (we),
		.waddr (idx_s1),
		.wdata (wdata),
		.re    (accept),
		.raddr (idx),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// bypass when the entry being read is written in the same cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			ctx_s1      <= ctx;
			idx_s1      <= idx;
			fwd_s1      <= we && (idx_s1 == idx);
			fwd_data_s1 <= wdata;
		end
	end

	assign stored = fwd_s1 ? fwd_data_s1 : rdata;

	always_comb begin
		sum_cb = {1'b0, stored[DATA_W-1:c420_pkg::SUM_W]} + {1'b0, ctx_s1.hsum_cb};
		sum_cr = {1'b0, stored[c420_pkg::SUM_W-1:0]} + {1'b0, ctx_s1.hsum_cr};
		cvalid = 1'b0;
		avg_cb = '0;
		avg_cr = '0;
		if (ctx_s1.hdone) begin
			if (ctx_s1.odd_row) begin
				cvalid = 1'b1;
				avg_cb = c420_pkg::PIX_W'(ctx_s1.pair ? (sum_cb >> 2) : (sum_cb >> 1));
				avg_cr = c420_pkg::PIX_W'(ctx_s1.pair ? (sum_cr >> 2) : (sum_cr >> 1));
			end else if (ctx_s1.last_row) begin
				cvalid = 1'b1;
				avg_cb = c420_pkg::PIX_W'(ctx_s1.pair ? (ctx_s1.hsum_cb >> 1) :
					ctx_s1.hsum_cb);
				avg_cr = c420_pkg::PIX_W'(ctx_s1.pair ? (ctx_s1.hsum_cr >> 1) :
					ctx_s1.hsum_cr);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			luma_q   <= ctx_s1.luma;
			cvalid_q <= cvalid;
			blue_q   <= avg_cb;
			red_q    <= avg_cr;
			ccol_q   <= cvalid ? ctx_s1.ccol : '0;
			crow_q   <= cvalid ? ctx_s1.crow : '0;
			fend_q   <= ctx_s1.frame_end;
		end
	end

	assign pix_out.valid        = out_valid_q;
	assign pix_out.luma_out     = luma_q;
	assign pix_out.chroma_valid = cvalid_q;
	assign pix_out.blue_avg     = blue_q;
	assign pix_out.red_avg      = red_q;
	assign pix_out.chroma_col   = ccol_q;
	assign pix_out.chroma_row   = crow_q;
	assign pix_out.frame_end    = fend_q;

endmodule

FILE: rtl/c420_line_mem.sv
// c420_line_mem: line store of even-row pair sums, one write and one read port
// registered read data holds until the next read; no dependencies

module c420_line_mem #(
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11,
	parameter int DATA_W = 18
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/c420_front.sv
// c420_front: frame registers, pixel position counters and horizontal pairing
// depends on c420_pkg and c420_cfg_if

module c420_front #(
	parameter int MAX_WIDTH = 4096,
	parameter int CW        = 13,
	parameter int ADDR_W    = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	c420_cfg_if.sink                   cfg,
	input  logic                       accept,
	input  logic [c420_pkg::PIX_W-1:0] luma,
	input  logic [c420_pkg::PIX_W-1:0] cr,
	input  logic [c420_pkg::PIX_W-1:0] cb,
	output c420_pkg::c420_ctx_t        ctx,
	output logic [ADDR_W-1:0]          idx
);

	logic [c420_pkg::CFG_W-1:0]  width_q;
	logic [c420_pkg::CFG_W-1:0]  height_q;
	logic [CW-1:0]               col_q;
	logic [c420_pkg::ROW_W-1:0]  row_q;
	logic [c420_pkg::PIX_W-1:0]  pend_cb_q;
	logic [c420_pkg::PIX_W-1:0]  pend_cr_q;
	logic [CW-1:0]               w_eff;
	logic [c420_pkg::CFG_W-1:0]  h_eff;
	logic                        last_col;
	logic                        last_row;
	logic                        cfg_write;
	logic                        cfg_hit;

	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid && cfg.ready;
	assign cfg_hit   = (cfg.index == c420_pkg::REG_WIDTH) ||
		(cfg.index == c420_pkg::REG_HEIGHT);

	always_comb begin
		if (width_q == '0) begin
			w_eff = CW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = c420_pkg::CFG_W'(1);
		end else if (32'(height_q) > 32'(c420_pkg::HEIGHT_MAX)) begin
			h_eff = c420_pkg::CFG_W'(c420_pkg::HEIGHT_MAX);
		end else begin
			h_eff = height_q;
		end
	end

	assign last_col = ({1'b0, col_q} + (CW + 1)'(1)) >= {1'b0, w_eff};
	assign last_row = ({1'b0, row_q} + c420_pkg::CFG_W'(1)) >= h_eff;
	assign idx      = ADDR_W'(col_q >> 1);

	always_comb begin
		ctx           = '0;
		ctx.luma      = luma;
		ctx.odd_row   = row_q[0];
		ctx.last_row  = last_row;
		ctx.frame_end = last_col && last_row;
		ctx.ccol      = c420_pkg::POS_OUT_W'(col_q >> 1);
		ctx.crow      = c420_pkg::POS_OUT_W'(row_q >> 1);
		if (col_q[0]) begin
			ctx.hsum_cb = {1'b0, pend_cb_q} + {1'b0, cb};
			ctx.hsum_cr = {1'b0, pend_cr_q} + {1'b0, cr};
			ctx.pair    = 1'b1;
			ctx.hdone   = 1'b1;
		end else if (last_col) begin
			ctx.hsum_cb = {1'b0, cb};
			ctx.hsum_cr = {1'b0, cr};
			ctx.hdone   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= c420_pkg::WIDTH_RESET;
			height_q  <= c420_pkg::HEIGHT_RESET;
			col_q     <= '0;
			row_q     <= '0;
			pend_cb_q <= '0;
			pend_cr_q <= '0;
		end else if (cfg_write) begin
			if (cfg.index == c420_pkg::REG_WIDTH) begin
				width_q <= cfg.data;
			end
			if (cfg.index == c420_pkg::REG_HEIGHT) begin
				height_q <= cfg.data;
			end
			if (cfg_hit) begin
				col_q <= '0;
				row_q <= '0;
			end
		end else if (accept) begin
			if (!col_q[0] && !last_col) begin
				pend_cb_q <= cb;
				pend_cr_q <= cr;
			end
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + c420_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule
